@@ hdl/lir_pkg.sv @@
`timescale 1ns / 1ps
// Package for the linear interpolation resampler.
// Holds widths, limits, the controller state type and the command and status structs.
// Depends on nothing.
package lir_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int FRAC_W          = 16;
  localparam int OC_W            = 7;
  localparam int DEN_W           = 6;
  localparam int OC_MIN          = 3;
  localparam int OC_MAX          = 64;
  localparam int OC_RESET        = 25;
  localparam int MAX_SAMPLES_DEF = 64;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_ADDR,
    ST_MUL,
    ST_MIX,
    ST_FIN_ADDR,
    ST_FIN_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic mul;
    logic emit;
    logic emit_final;
    logic sel_final;
  } cmd_t;

  typedef struct packed {
    logic run_start;
    logic div_done;
    logic out_free;
    logic interp_last;
  } status_t;

endpackage

@@ hdl/lir_stream_if.sv @@
`timescale 1ns / 1ps
// Stream interfaces for input samples and resampled output samples.
// Depends on lir_pkg for the sample width.
interface lir_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lir_pkg::SAMPLE_W-1:0]  sample_in;
  logic                                 last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink (input valid, input sample_in, input last_in, output ready);
endinterface

interface lir_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lir_pkg::SAMPLE_W-1:0]  sample_out;
  logic                                 last_out;

  modport source (output valid, output sample_out, output last_out, input ready);
  modport sink (input valid, input sample_out, input last_out, output ready);
endinterface

@@ hdl/linear_interp_resampler_core.sv @@
`timescale 1ns / 1ps
// Linear interpolation resampler with 16-bit samples and a 7.16 fixed point phase for 64 samples.
// Input items are taken while loading. The item marked last starts a step division at one
// quotient bit per cycle, then a store read, multiply and mix step for each output item;
// the final item is read straight from the store. Input is not taken again until the run is
// done, and output stalls hold the run.
// Synchronous active high reset returns to loading with an empty store and count 25.
// Depends on lir_pkg, lir_stream_if, lir_ctrl and lir_datapath.
module linear_interp_resampler_core #(
  parameter int MAX_SAMPLES = lir_pkg::MAX_SAMPLES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [lir_pkg::OC_W-1:0] cfg_data,
  lir_in_if.sink                   in_stream,
  lir_out_if.source                out_stream
);

  lir_pkg::cmd_t    cmd;
  lir_pkg::status_t status;

  lir_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  lir_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_stream  (in_stream),
    .out_stream (out_stream),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

@@ hdl/lir_ram.sv @@
`timescale 1ns / 1ps
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
module lir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hdl/lir_div.sv @@
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
// Depends on lir_pkg for the divisor width.
module lir_div #(
  parameter int NUM_W = 23
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [lir_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [NUM_W-1:0]          quo
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [lir_pkg::DEN_W-1:0] divisor;
  logic [lir_pkg::DEN_W-1:0] rem;
  logic [lir_pkg::DEN_W:0]   trial;
  logic                      fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign done  = busy && (cnt == CNT_W'(NUM_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      busy <= !done;
      cnt  <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quo <= '0;
    end else if (start) begin
      quo     <= num;
      rem     <= '0;
      divisor <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= lir_pkg::DEN_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[lir_pkg::DEN_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

@@ hdl/lir_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine for the resampler: load, divide, then walk the outputs.
// Depends on lir_pkg for the state type and the command and status structs.
module lir_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  lir_pkg::status_t status,
  output lir_pkg::cmd_t    cmd
);

  lir_pkg::state_t state;
  lir_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lir_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      lir_pkg::ST_LOAD: begin
        cmd.take = 1'b1;
        if (status.run_start) begin
          state_next = lir_pkg::ST_DIV;
        end
      end
      lir_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_next = lir_pkg::ST_ADDR;
        end
      end
      lir_pkg::ST_ADDR: begin
        state_next = lir_pkg::ST_MUL;
      end
      lir_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = lir_pkg::ST_MIX;
      end
      lir_pkg::ST_MIX: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.interp_last) begin
            state_next = lir_pkg::ST_FIN_ADDR;
          end else begin
            state_next = lir_pkg::ST_ADDR;
          end
        end
      end
      lir_pkg::ST_FIN_ADDR: begin
        cmd.sel_final = 1'b1;
        state_next    = lir_pkg::ST_FIN_EMIT;
      end
      lir_pkg::ST_FIN_EMIT: begin
        cmd.sel_final = 1'b1;
        if (status.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = lir_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = lir_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

@@ hdl/lir_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the resampler: sample store, step divider, phase walk, mix and output register.
// Depends on lir_pkg, lir_stream_if, lir_ram and lir_div.
module lir_datapath #(
  parameter int MAX_SAMPLES = lir_pkg::MAX_SAMPLES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [lir_pkg::OC_W-1:0] cfg_data,
  lir_in_if.sink                   in_stream,
  lir_out_if.source                out_stream,
  input  lir_pkg::cmd_t            cmd,
  output lir_pkg::status_t         status
);

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int PW  = CW + lir_pkg::FRAC_W;
  localparam int SW  = lir_pkg::SAMPLE_W;
  localparam int OW  = lir_pkg::OC_W;
  localparam int FW  = lir_pkg::FRAC_W;
  localparam int DW  = lir_pkg::DEN_W;
  localparam int PRW = SW + FW + 2;

  logic [OW-1:0]        output_count;
  logic [CW-1:0]        loaded_count;
  logic [CW-1:0]        run_n;
  logic [OW-1:0]        run_oc;
  logic                 single;
  logic [PW-1:0]        phase;
  logic [OW-2:0]        k;

  logic                 accept;
  logic                 full;
  logic [CW-1:0]        n_new;
  logic [OW-1:0]        oc_sat;
  logic [PW-1:0]        div_num;
  logic [DW-1:0]        div_den;
  logic [PW-1:0]        phase_step;
  logic                 div_done;

  logic [CW-1:0]        ipart;
  logic [CW-1:0]        nm2;
  logic [CW-1:0]        idx;
  logic [AW-1:0]        raddr_a;
  logic [AW-1:0]        raddr_b;
  logic [SW-1:0]        rdata_a;
  logic [SW-1:0]        rdata_b;

  logic signed [SW:0]   diff;
  logic signed [FW:0]   frac;
  logic signed [PRW-1:0] prod;
  logic signed [SW-1:0] a_reg;
  logic signed [SW+1:0] mixed;

  logic                 out_valid;
  logic signed [SW-1:0] out_sample;
  logic                 out_last;

  assign accept = in_stream.valid && cmd.take;
  assign full   = loaded_count == CW'(MAX_SAMPLES);
  assign n_new  = full ? loaded_count : loaded_count + CW'(1);

  always_comb begin
    if (output_count < OW'(lir_pkg::OC_MIN)) begin
      oc_sat = OW'(lir_pkg::OC_MIN);
    end else if (output_count > OW'(lir_pkg::OC_MAX)) begin
      oc_sat = OW'(lir_pkg::OC_MAX);
    end else begin
      oc_sat = output_count;
    end
  end

  assign div_num = (n_new >= CW'(2)) ? {n_new - CW'(2), {FW{1'b0}}} : '0;
  assign div_den = DW'(oc_sat - OW'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      output_count <= OW'(lir_pkg::OC_RESET);
    end else if (cfg_we) begin
      output_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
    end else if (accept) begin
      if (in_stream.last_in) begin
        loaded_count <= '0;
      end else if (!full) begin
        loaded_count <= loaded_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_n  <= '0;
      run_oc <= OW'(lir_pkg::OC_MIN);
      single <= 1'b0;
    end else if (accept && in_stream.last_in) begin
      run_n  <= n_new;
      run_oc <= oc_sat;
      single <= n_new < CW'(2);
    end
  end

  lir_div #(
    .NUM_W (PW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (accept && in_stream.last_in),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (phase_step)
  );

  assign ipart = phase[PW-1:FW];
  assign nm2   = run_n - CW'(2);

  always_comb begin
    if (single) begin
      idx = '0;
    end else if (ipart > nm2) begin
      idx = nm2;
    end else begin
      idx = ipart;
    end
  end

  always_comb begin
    if (cmd.sel_final) begin
      raddr_a = AW'(run_n - CW'(1));
    end else begin
      raddr_a = idx[AW-1:0];
    end
    raddr_b = idx[AW-1:0] + AW'(1);
  end

  lir_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk     (clk),
    .we      (accept && !full),
    .waddr   (loaded_count[AW-1:0]),
    .wdata   (in_stream.sample_in),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign diff = $signed({rdata_b[SW-1], rdata_b}) - $signed({rdata_a[SW-1], rdata_a});
  assign frac = $signed({1'b0, phase[FW-1:0]});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod  <= PRW'(diff * frac);
      a_reg <= $signed(rdata_a);
    end
  end

  assign mixed = $signed({a_reg[SW-1], a_reg[SW-1], a_reg}) + prod[PRW-1:FW];

  assign status.interp_last = {1'b0, k} == run_oc - OW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      k     <= '0;
    end else if (accept && in_stream.last_in) begin
      phase <= '0;
      k     <= '0;
    end else if (cmd.emit) begin
      if (!status.interp_last) begin
        phase <= phase + phase_step;
      end
      k <= k + (OW - 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_final) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample <= single ? a_reg : mixed[SW-1:0];
      out_last   <= 1'b0;
    end else if (cmd.emit_final) begin
      out_sample <= $signed(rdata_a);
      out_last   <= 1'b1;
    end
  end

  assign in_stream.ready       = cmd.take;
  assign out_stream.valid      = out_valid;
  assign out_stream.sample_out = out_sample;
  assign out_stream.last_out   = out_last;

  assign status.run_start = accept && in_stream.last_in;
  assign status.div_done  = div_done;
  assign status.out_free  = !out_valid || out_stream.ready;

endmodule
